// ----- src/d8fd_pkg.sv -----
// Shared types, constants and codes of the D8 flow-direction window block.
`timescale 1ns / 1ps

package d8fd_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 4096;

    localparam int ELEV_W          = 16;
    localparam int GRID_WIDTH_W    = 11;
    localparam int GRID_HEIGHT_W   = 13;
    localparam int GRID_WIDTH_RST  = 1024;
    localparam int GRID_HEIGHT_RST = 1024;

    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 3;

    localparam int DIR_COUNT       = 8;
    localparam int WEIGHT_W        = 11;
    localparam int SCORE_W         = ELEV_W + WEIGHT_W;
    localparam logic [WEIGHT_W-1:0] CARD_WEIGHT = 11'd1414;
    localparam logic [WEIGHT_W-1:0] DIAG_WEIGHT = 11'd1000;

    localparam int QUEUE_DEPTH     = 8;

    typedef logic [ELEV_W-1:0] elev_t;
    typedef logic [9:0]        col_out_t;
    typedef logic [11:0]       row_out_t;
    typedef logic [3:0]        dir_t;

    localparam dir_t DIR_N   = 4'd0;
    localparam dir_t DIR_NE  = 4'd1;
    localparam dir_t DIR_E   = 4'd2;
    localparam dir_t DIR_SE  = 4'd3;
    localparam dir_t DIR_S   = 4'd4;
    localparam dir_t DIR_SW  = 4'd5;
    localparam dir_t DIR_W   = 4'd6;
    localparam dir_t DIR_NW  = 4'd7;
    localparam dir_t DIR_PIT = 4'd8;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

// ----- src/d8fd_if.sv -----
// Valid/ready stream interfaces for elevation samples and direction results.
`timescale 1ns / 1ps

interface d8fd_in_if;
    logic                  valid;
    logic                  ready;
    d8fd_pkg::elev_t       elevation_sample;

    modport source (output valid, output elevation_sample, input ready);
    modport sink   (input valid, input elevation_sample, output ready);
endinterface

interface d8fd_out_if;
    logic                  valid;
    logic                  ready;
    d8fd_pkg::col_out_t    cell_column;
    d8fd_pkg::row_out_t    cell_row;
    d8fd_pkg::dir_t        flow_dir;
    logic                  run_last;
    logic                  frame_last;

    modport source (output valid, output cell_column, output cell_row, output flow_dir,
                    output run_last, output frame_last, input ready);
    modport sink   (input valid, input cell_column, input cell_row, input flow_dir,
                    input run_last, input frame_last, output ready);
endinterface

// ----- src/d8_flow_direction_window.sv -----
// Top level: streaming D8 steepest-descent flow direction over a 3x3 window.
`timescale 1ns / 1ps

// Elevation samples enter on the samples channel in raster order, one beat per cell.
// Each accepted sample yields zero to three result beats on the results channel:
// the window center one row up and one column left, the last cell of the previous
// row when the sample closes a row, and the sample's own cell on the last row.
// run_last marks the final beat of a sample, frame_last the beat of the last cell.
// grid_width (address 0) and grid_height (address 4) are written over the APB
// port while the block is idle; any write restarts the frame at row 0, column 0.
// The two previous rows sit in one line RAM, read when a sample is accepted and
// written back in the following cycle; the next sample always reads another column.
// Each sample is scored, compared and queued before its first result beat.
// A sample is taken every cycle while results drain at one beat per cycle; on the
// last row a sample brings up to three beats, so the input then runs at the pace
// of the result port, one beat per cycle.
// Results wait in an eight-entry queue; a stalled receiver fills it and then holds
// off the input, with nothing lost. Reset empties the pipeline and the queue,
// restores both registers to 1024 and needs no clearing pass over the line RAM.
module d8_flow_direction_window #(
    parameter int MAX_WIDTH  = d8fd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = d8fd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [d8fd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [d8fd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [d8fd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    d8fd_in_if.sink                           samples,
    d8fd_out_if.source                        results
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ELEV_W = d8fd_pkg::ELEV_W;
    localparam int RAM_W  = 2 * ELEV_W;
    localparam int SC_W   = d8fd_pkg::SCORE_W;
    localparam int NDIR   = d8fd_pkg::DIR_COUNT;
    localparam int QD     = d8fd_pkg::QUEUE_DEPTH;
    localparam int QA_W   = $clog2(QD);
    localparam int QC_W   = QA_W + 1;
    localparam int GW_W   = d8fd_pkg::GRID_WIDTH_W;
    localparam int GH_W   = d8fd_pkg::GRID_HEIGHT_W;
    localparam int DW     = d8fd_pkg::CFG_DATA_W;

    localparam int RST_W_EFF = (d8fd_pkg::GRID_WIDTH_RST > MAX_WIDTH) ?
                               MAX_WIDTH : d8fd_pkg::GRID_WIDTH_RST;
    localparam int RST_H_EFF = (d8fd_pkg::GRID_HEIGHT_RST > MAX_HEIGHT) ?
                               MAX_HEIGHT : d8fd_pkg::GRID_HEIGHT_RST;
    localparam logic [COL_W-1:0] RST_COL_LAST = COL_W'(RST_W_EFF - 1);
    localparam logic [ROW_W-1:0] RST_ROW_LAST = ROW_W'(RST_H_EFF - 1);

    typedef struct packed {
        logic [2:0]       mask;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        d8fd_pkg::dir_t   dir_a;
        d8fd_pkg::dir_t   dir_b;
        d8fd_pkg::dir_t   dir_c;
        logic             frame_end;
    } group_t;

    // Configuration registers.
    logic [GW_W-1:0]     grid_width_reg, grid_width_next;
    logic [GH_W-1:0]     grid_height_reg, grid_height_next;
    logic [COL_W-1:0]    col_last_reg, col_last_next;
    logic [ROW_W-1:0]    row_last_reg, row_last_next;
    logic                cfg_we;
    d8fd_pkg::reg_idx_t  cfg_idx;
    logic [31:0]         width_ext, height_ext, width_eff, height_eff;

    // Raster position and window.
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                last_col_now, last_row_now;
    d8fd_pkg::elev_t     win_reg [6];
    d8fd_pkg::elev_t     win_next [6];
    logic                accept;

    // First stage: line RAM data is valid here.
    logic                p1_valid_reg;
    d8fd_pkg::elev_t     p1_sample_reg;
    logic [COL_W-1:0]    p1_col_reg;
    logic [ROW_W-1:0]    p1_row_reg;
    logic                p1_last_col_reg, p1_last_row_reg;
    logic [RAM_W-1:0]    line_rd;
    d8fd_pkg::elev_t     top, mid, centre;
    d8fd_pkg::elev_t     nb [NDIR];
    logic [SC_W-1:0]     score_next [NDIR];
    logic                row_nz, col_nz, row_is_one, col_is_one;
    group_t              p1_grp;
    logic                p1_border;

    // Second stage: scores.
    logic                p2_valid_reg;
    group_t              p2_grp_reg;
    logic                p2_border_reg;
    logic [SC_W-1:0]     p2_score_reg [NDIR];
    logic [SC_W-1:0]     l1_score [4];
    logic [2:0]          l1_idx [4];
    logic [SC_W-1:0]     l2_score [2];
    logic [2:0]          l2_idx [2];

    // Third stage: last compare.
    logic                p3_valid_reg;
    group_t              p3_grp_reg;
    logic                p3_border_reg;
    logic [SC_W-1:0]     p3_score_reg [2];
    logic [2:0]          p3_idx_reg [2];
    logic [SC_W-1:0]     best_score;
    logic [2:0]          best_idx;
    group_t              grp_push;

    // Result queue.
    group_t              q_reg [QD];
    logic [QA_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]     q_count_reg, q_count_next;
    logic [2:0]          done_reg, done_next;
    logic [QC_W:0]       in_flight;
    group_t              head;
    logic [2:0]          pending, cur;
    logic                run_last, beat_out, pop_group;
    logic [COL_W-1:0]    sel_col;
    logic [ROW_W-1:0]    sel_row;
    d8fd_pkg::dir_t      sel_dir;
    logic                sel_frame;

    // ---------------------------------------------------------------- config port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = d8fd_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        width_ext  = 32'(pwdata[GW_W-1:0]);
        height_ext = 32'(pwdata[GH_W-1:0]);
        if (width_ext < 32'd2)
        begin
            width_eff = 32'd2;
        end
        else if (width_ext > 32'(MAX_WIDTH))
        begin
            width_eff = 32'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        if (height_ext < 32'd2)
        begin
            height_eff = 32'd2;
        end
        else if (height_ext > 32'(MAX_HEIGHT))
        begin
            height_eff = 32'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_ext;
        end
    end

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        col_last_next    = col_last_reg;
        row_last_next    = row_last_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                d8fd_pkg::REG_GRID_WIDTH:
                begin
                    grid_width_next = pwdata[GW_W-1:0];
                    col_last_next   = COL_W'(width_eff - 32'd1);
                end
                d8fd_pkg::REG_GRID_HEIGHT:
                begin
                    grid_height_next = pwdata[GH_W-1:0];
                    row_last_next    = ROW_W'(height_eff - 32'd1);
                end
                default:
                begin
                    grid_width_next = grid_width_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            d8fd_pkg::REG_GRID_WIDTH:  prdata = DW'(grid_width_reg);
            d8fd_pkg::REG_GRID_HEIGHT: prdata = DW'(grid_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- position
    assign accept       = samples.valid && samples.ready;
    assign last_col_now = (col_reg >= col_last_reg);
    assign last_row_now = (row_reg >= row_last_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col_now)
            begin
                col_next = '0;
                row_next = last_row_now ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        win_next = win_reg;
        if (cfg_we)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_next[i] = '0;
            end
        end
        else if (p1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i] = win_reg[3 + i];
            end
            win_next[3] = top;
            win_next[4] = mid;
            win_next[5] = p1_sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GW_W'(d8fd_pkg::GRID_WIDTH_RST);
            grid_height_reg <= GH_W'(d8fd_pkg::GRID_HEIGHT_RST);
            col_last_reg    <= RST_COL_LAST;
            row_last_reg    <= RST_ROW_LAST;
            col_reg         <= '0;
            row_reg         <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            col_last_reg    <= col_last_next;
            row_last_reg    <= row_last_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            win_reg         <= win_next;
        end
    end

    // ---------------------------------------------------------------- line RAM
    d8fd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_col_reg),
        .wr_data ({mid, p1_sample_reg}),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_sample_reg   <= samples.elevation_sample;
            p1_col_reg      <= col_reg;
            p1_row_reg      <= row_reg;
            p1_last_col_reg <= last_col_now;
            p1_last_row_reg <= last_row_now;
        end
    end

    // Rows that do not exist yet in this frame read as zero.
    assign top    = (p1_row_reg > ROW_W'(1)) ? line_rd[RAM_W-1:ELEV_W] : '0;
    assign mid    = (p1_row_reg != '0) ? line_rd[ELEV_W-1:0] : '0;
    assign centre = win_reg[4];

    always_comb
    begin
        nb[0] = win_reg[3];
        nb[1] = top;
        nb[2] = mid;
        nb[3] = p1_sample_reg;
        nb[4] = win_reg[5];
        nb[5] = win_reg[2];
        nb[6] = win_reg[1];
        nb[7] = win_reg[0];
        for (int d = 0; d < NDIR; d++)
        begin
            if (nb[d] < centre)
            begin
                score_next[d] = SC_W'(centre - nb[d]) *
                                SC_W'(d[0] ? d8fd_pkg::DIAG_WEIGHT : d8fd_pkg::CARD_WEIGHT);
            end
            else
            begin
                score_next[d] = '0;
            end
        end
    end

    assign row_nz     = (p1_row_reg != '0);
    assign col_nz     = (p1_col_reg != '0);
    assign row_is_one = (p1_row_reg == ROW_W'(1));
    assign col_is_one = (p1_col_reg == COL_W'(1));
    assign p1_border  = row_is_one || col_is_one;

    always_comb
    begin
        p1_grp.mask      = {p1_last_row_reg, row_nz & p1_last_col_reg, row_nz & col_nz};
        p1_grp.col       = p1_col_reg;
        p1_grp.row       = p1_row_reg;
        p1_grp.dir_a     = row_is_one ? d8fd_pkg::DIR_N : d8fd_pkg::DIR_SW;
        p1_grp.dir_b     = row_is_one ? d8fd_pkg::DIR_N : d8fd_pkg::DIR_NE;
        p1_grp.frame_end = p1_last_col_reg;
        if (!row_nz)
        begin
            p1_grp.dir_c = d8fd_pkg::DIR_N;
        end
        else if (p1_last_col_reg)
        begin
            p1_grp.dir_c = d8fd_pkg::DIR_NE;
        end
        else
        begin
            p1_grp.dir_c = d8fd_pkg::DIR_SE;
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_ff @(posedge clk)
    begin
        p2_grp_reg    <= p1_grp;
        p2_border_reg <= p1_border;
        p2_score_reg  <= score_next;
    end

    // On a tie the lower direction keeps the place.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (p2_score_reg[2 * k + 1] > p2_score_reg[2 * k])
            begin
                l1_score[k] = p2_score_reg[2 * k + 1];
                l1_idx[k]   = 3'(2 * k + 1);
            end
            else
            begin
                l1_score[k] = p2_score_reg[2 * k];
                l1_idx[k]   = 3'(2 * k);
            end
        end
        for (int k = 0; k < 2; k++)
        begin
            if (l1_score[2 * k + 1] > l1_score[2 * k])
            begin
                l2_score[k] = l1_score[2 * k + 1];
                l2_idx[k]   = l1_idx[2 * k + 1];
            end
            else
            begin
                l2_score[k] = l1_score[2 * k];
                l2_idx[k]   = l1_idx[2 * k];
            end
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_ff @(posedge clk)
    begin
        p3_grp_reg    <= p2_grp_reg;
        p3_border_reg <= p2_border_reg;
        p3_score_reg  <= l2_score;
        p3_idx_reg    <= l2_idx;
    end

    always_comb
    begin
        if (p3_score_reg[1] > p3_score_reg[0])
        begin
            best_score = p3_score_reg[1];
            best_idx   = p3_idx_reg[1];
        end
        else
        begin
            best_score = p3_score_reg[0];
            best_idx   = p3_idx_reg[0];
        end
        grp_push = p3_grp_reg;
        if (!p3_border_reg)
        begin
            grp_push.dir_a = (best_score == '0) ? d8fd_pkg::DIR_PIT : {1'b0, best_idx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg && (p1_grp.mask != 3'b000);
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // ---------------------------------------------------------------- result queue
    assign in_flight = (QC_W + 1)'(q_count_reg) + (QC_W + 1)'(p1_valid_reg)
                     + (QC_W + 1)'(p2_valid_reg) + (QC_W + 1)'(p3_valid_reg);
    assign samples.ready = (in_flight < (QC_W + 1)'(QD));

    always_ff @(posedge clk)
    begin
        if (p3_valid_reg)
        begin
            q_reg[wr_ptr_reg] <= grp_push;
        end
    end

    assign head    = q_reg[rd_ptr_reg];
    assign pending = head.mask & ~done_reg;

    always_comb
    begin
        if (pending[0])
        begin
            cur       = 3'b001;
            sel_col   = head.col - COL_W'(1);
            sel_row   = head.row - ROW_W'(1);
            sel_dir   = head.dir_a;
            sel_frame = 1'b0;
        end
        else if (pending[1])
        begin
            cur       = 3'b010;
            sel_col   = head.col;
            sel_row   = head.row - ROW_W'(1);
            sel_dir   = head.dir_b;
            sel_frame = 1'b0;
        end
        else
        begin
            cur       = 3'b100;
            sel_col   = head.col;
            sel_row   = head.row;
            sel_dir   = head.dir_c;
            sel_frame = head.frame_end;
        end
    end

    assign run_last  = ((pending & ~cur) == 3'b000);
    assign beat_out  = results.valid && results.ready;
    assign pop_group = beat_out && run_last;

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg + QA_W'(p3_valid_reg);
        rd_ptr_next  = rd_ptr_reg + QA_W'(pop_group);
        q_count_next = q_count_reg + QC_W'(p3_valid_reg) - QC_W'(pop_group);
        done_next    = done_reg;
        if (beat_out)
        begin
            done_next = run_last ? 3'b000 : (done_reg | cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
            done_reg    <= 3'b000;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
            done_reg    <= done_next;
        end
    end

    assign results.valid       = (q_count_reg != '0);
    assign results.cell_column = d8fd_pkg::col_out_t'(sel_col);
    assign results.cell_row    = d8fd_pkg::row_out_t'(sel_row);
    assign results.flow_dir    = sel_dir;
    assign results.run_last    = run_last;
    assign results.frame_last  = sel_frame;

endmodule

// ----- src/d8fd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module d8fd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/d8fd_checker.sv -----
// Port-level checks of the D8 flow-direction block and their binding to it.
`timescale 1ns / 1ps

module d8fd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 res_valid,
    input logic                 res_ready,
    input d8fd_pkg::col_out_t   res_column,
    input d8fd_pkg::row_out_t   res_row,
    input d8fd_pkg::dir_t       res_dir,
    input logic                 res_run_last,
    input logic                 res_frame_last
);

    // No result beat is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result beat offered during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({res_column, res_row, res_dir, res_run_last, res_frame_last}))
        else $error("stalled result beat changed");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_dir <= d8fd_pkg::DIR_PIT)
        else $error("direction code out of range");

    // The last cell of a frame closes its sample's beats and sits on the east edge.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_frame_last |-> res_run_last && res_dir == d8fd_pkg::DIR_NE)
        else $error("frame end beat malformed");

    // A cell in the west column always has a border direction.
    a_west_edge: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_column == '0 |-> res_dir == d8fd_pkg::DIR_N
            || res_dir == d8fd_pkg::DIR_SW || res_dir == d8fd_pkg::DIR_SE)
        else $error("west column cell without border direction");

endmodule

bind d8_flow_direction_window d8fd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .res_column     (results.cell_column),
    .res_row        (results.cell_row),
    .res_dir        (results.flow_dir),
    .res_run_last   (results.run_last),
    .res_frame_last (results.frame_last)
);
